>>> rtl/depth_pixel_to_point_top_defines.svh
// Assertion macros shared by the RTL. They expect clk and rst_n in scope.
`ifndef DEPTH_PIXEL_TO_POINT_TOP_DEFINES_SVH
`define DEPTH_PIXEL_TO_POINT_TOP_DEFINES_SVH

// Checks that a condition implies another one in the same cycle.
`define DPP_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Checks that a condition implies another one in the next cycle.
`define DPP_ASSERT_NXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

>>> rtl/dpp_pkg.sv
`default_nettype none

package dpp_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;
    localparam int COLOR_BITS = 8;
    localparam int CENTER_W   = 12;
    localparam int SCALE_W    = 24;
    localparam int Q_FRAC     = 16;
    localparam int POINT_W    = 32;
    localparam int RGB_W      = 3 * COLOR_BITS;

    localparam int OFF_W = (COORD_BITS > CENTER_W) ? COORD_BITS : CENTER_W;
    localparam int P1_W  = OFF_W + DEPTH_BITS;
    localparam int P2_W  = P1_W + SCALE_W;
    localparam int Y_W   = DEPTH_BITS + SCALE_W;

    localparam int IN_BITS   = DEPTH_BITS + 2 * COORD_BITS + RGB_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 3 * POINT_W + RGB_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int NUM_REGS = 5;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int IDX_W    = ADDR_W - 2;

    localparam logic [CENTER_W-1:0] CENTER_X_RST    = CENTER_W'(160);
    localparam logic [CENTER_W-1:0] CENTER_Y_RST    = CENTER_W'(120);
    localparam logic [SCALE_W-1:0]  RECIP_X_RST     = SCALE_W'(35791);
    localparam logic [SCALE_W-1:0]  RECIP_Y_RST     = SCALE_W'(35791);
    localparam logic [SCALE_W-1:0]  RECIP_DEPTH_RST = SCALE_W'(4294967);

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RECIP_X,
        REG_RECIP_Y,
        REG_RECIP_DEPTH
    } reg_idx_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [SCALE_W-1:0]  recip_x;
        logic [SCALE_W-1:0]  recip_y;
        logic [SCALE_W-1:0]  recip_depth;
    } cfg_t;

    typedef struct packed {
        logic                  x_neg;
        logic [OFF_W-1:0]      x_off;
        logic                  z_neg;
        logic [OFF_W-1:0]      z_off;
        logic [DEPTH_BITS-1:0] depth;
        logic [RGB_W-1:0]      color;
    } front_t;

    typedef struct packed {
        logic             x_neg;
        logic [P1_W-1:0]  x_p1;
        logic             z_neg;
        logic [P1_W-1:0]  z_p1;
        logic [Y_W-1:0]   y_mag;
        logic [RGB_W-1:0] color;
    } mid_t;

    typedef struct packed {
        logic             x_neg;
        logic [P2_W-1:0]  x_mag;
        logic             z_neg;
        logic [P2_W-1:0]  z_mag;
        logic [Y_W-1:0]   y_mag;
        logic [RGB_W-1:0] color;
    } prod_t;

endpackage

`default_nettype wire

>>> rtl/dpp_cfg.sv
`default_nettype none

module dpp_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dpp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dpp_pkg::DATA_W-1:0] pwdata,
    output logic      [dpp_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output dpp_pkg::cfg_t                   cfg
);

    dpp_pkg::cfg_t     cfg_reg;
    dpp_pkg::cfg_t     cfg_next;
    dpp_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = dpp_pkg::reg_idx_t'(paddr[dpp_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dpp_pkg::REG_CENTER_X:    cfg_next.center_x    = pwdata[dpp_pkg::CENTER_W-1:0];
                dpp_pkg::REG_CENTER_Y:    cfg_next.center_y    = pwdata[dpp_pkg::CENTER_W-1:0];
                dpp_pkg::REG_RECIP_X:     cfg_next.recip_x     = pwdata[dpp_pkg::SCALE_W-1:0];
                dpp_pkg::REG_RECIP_Y:     cfg_next.recip_y     = pwdata[dpp_pkg::SCALE_W-1:0];
                dpp_pkg::REG_RECIP_DEPTH: cfg_next.recip_depth = pwdata[dpp_pkg::SCALE_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dpp_pkg::REG_CENTER_X:    prdata = dpp_pkg::DATA_W'(cfg_reg.center_x);
            dpp_pkg::REG_CENTER_Y:    prdata = dpp_pkg::DATA_W'(cfg_reg.center_y);
            dpp_pkg::REG_RECIP_X:     prdata = dpp_pkg::DATA_W'(cfg_reg.recip_x);
            dpp_pkg::REG_RECIP_Y:     prdata = dpp_pkg::DATA_W'(cfg_reg.recip_y);
            dpp_pkg::REG_RECIP_DEPTH: prdata = dpp_pkg::DATA_W'(cfg_reg.recip_depth);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= dpp_pkg::CENTER_X_RST;
            cfg_reg.center_y    <= dpp_pkg::CENTER_Y_RST;
            cfg_reg.recip_x     <= dpp_pkg::RECIP_X_RST;
            cfg_reg.recip_y     <= dpp_pkg::RECIP_Y_RST;
            cfg_reg.recip_depth <= dpp_pkg::RECIP_DEPTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dpp_front.sv
`default_nettype none

module dpp_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dpp_pkg::cfg_t                  cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [dpp_pkg::DEPTH_BITS-1:0] depth,
    input  wire logic [dpp_pkg::COORD_BITS-1:0] column,
    input  wire logic [dpp_pkg::COORD_BITS-1:0] row,
    input  wire logic [dpp_pkg::COLOR_BITS-1:0] red,
    input  wire logic [dpp_pkg::COLOR_BITS-1:0] green,
    input  wire logic [dpp_pkg::COLOR_BITS-1:0] blue,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output dpp_pkg::front_t                     out_data
);

    logic                            valid_reg;
    logic                            valid_next;
    dpp_pkg::front_t                 data_reg;
    dpp_pkg::front_t                 data_next;
    logic [dpp_pkg::OFF_W-1:0]       col_w;
    logic [dpp_pkg::OFF_W-1:0]       row_w;
    logic [dpp_pkg::OFF_W-1:0]       cx_w;
    logic [dpp_pkg::OFF_W-1:0]       cy_w;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign col_w = dpp_pkg::OFF_W'(column);
    assign row_w = dpp_pkg::OFF_W'(row);
    assign cx_w  = dpp_pkg::OFF_W'(cfg.center_x);
    assign cy_w  = dpp_pkg::OFF_W'(cfg.center_y);

    // A pixel with no depth measurement is taken but dropped here.
    assign valid_next = in_valid && (depth != '0);

    always_comb
    begin
        data_next.x_neg = col_w < cx_w;
        data_next.x_off = data_next.x_neg ? (cx_w - col_w) : (col_w - cx_w);
        // The camera row axis points down, so the output z uses center minus row.
        data_next.z_neg = cy_w < row_w;
        data_next.z_off = data_next.z_neg ? (row_w - cy_w) : (cy_w - row_w);
        data_next.depth = depth;
        data_next.color = {red, green, blue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && valid_next)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dpp_scale.sv
`default_nettype none

module dpp_scale (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dpp_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dpp_pkg::front_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dpp_pkg::prod_t       out_data
);

    logic            mid_valid_reg;
    dpp_pkg::mid_t   mid_reg;
    dpp_pkg::mid_t   mid_next;
    logic            prod_valid_reg;
    dpp_pkg::prod_t  prod_reg;
    dpp_pkg::prod_t  prod_next;
    logic            prod_ready;

    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_ready   = !mid_valid_reg || prod_ready;
    assign out_valid  = prod_valid_reg;
    assign out_data   = prod_reg;

    // First multiplier rank: pixel offset times depth, and depth times its scale.
    always_comb
    begin
        mid_next.x_neg = in_data.x_neg;
        mid_next.x_p1  = dpp_pkg::P1_W'(in_data.x_off) * dpp_pkg::P1_W'(in_data.depth);
        mid_next.z_neg = in_data.z_neg;
        mid_next.z_p1  = dpp_pkg::P1_W'(in_data.z_off) * dpp_pkg::P1_W'(in_data.depth);
        mid_next.y_mag = dpp_pkg::Y_W'(in_data.depth) * dpp_pkg::Y_W'(cfg.recip_depth);
        mid_next.color = in_data.color;
    end

    // Second multiplier rank: the offset products times the focal scales.
    always_comb
    begin
        prod_next.x_neg = mid_reg.x_neg;
        prod_next.x_mag = dpp_pkg::P2_W'(mid_reg.x_p1) * dpp_pkg::P2_W'(cfg.recip_x);
        prod_next.z_neg = mid_reg.z_neg;
        prod_next.z_mag = dpp_pkg::P2_W'(mid_reg.z_p1) * dpp_pkg::P2_W'(cfg.recip_y);
        prod_next.y_mag = mid_reg.y_mag;
        prod_next.color = mid_reg.color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                mid_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                prod_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mid_reg <= mid_next;
        end
        if (prod_ready && mid_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dpp_sat.sv
`default_nettype none

module dpp_sat (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire dpp_pkg::prod_t                in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dpp_pkg::M_TDATA_W-1:0]      out_data
);

    localparam int R_W = dpp_pkg::P2_W - dpp_pkg::Q_FRAC + 1;

    logic                                 valid_reg;
    logic [dpp_pkg::M_TDATA_W-1:0]        data_reg;
    logic [dpp_pkg::M_TDATA_W-1:0]        data_next;
    logic [dpp_pkg::POINT_W-1:0]          px;
    logic [dpp_pkg::POINT_W-1:0]          py;
    logic [dpp_pkg::POINT_W-1:0]          pz;

    // Rounds the magnitude half away from zero, applies the sign and saturates.
    function automatic logic [dpp_pkg::POINT_W-1:0] to_q16(
        input logic                    neg,
        input logic [dpp_pkg::P2_W-1:0] mag
    );
        logic [dpp_pkg::P2_W:0]        sum;
        logic [R_W-1:0]                r;
        logic [dpp_pkg::POINT_W-1:0]   q;
        sum = {1'b0, mag} + (dpp_pkg::P2_W + 1)'(1 << (dpp_pkg::Q_FRAC - 1));
        r   = sum[dpp_pkg::P2_W:dpp_pkg::Q_FRAC];
        if (neg)
        begin
            if (r >= R_W'(1) << (dpp_pkg::POINT_W - 1))
                q = {1'b1, {(dpp_pkg::POINT_W - 1){1'b0}}};
            else
                q = '0 - r[dpp_pkg::POINT_W-1:0];
        end
        else
        begin
            if (r > R_W'({(dpp_pkg::POINT_W - 1){1'b1}}))
                q = {1'b0, {(dpp_pkg::POINT_W - 1){1'b1}}};
            else
                q = r[dpp_pkg::POINT_W-1:0];
        end
        return q;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        px = to_q16(in_data.x_neg, in_data.x_mag);
        py = to_q16(1'b0, dpp_pkg::P2_W'(in_data.y_mag));
        pz = to_q16(in_data.z_neg, in_data.z_mag);
        data_next = dpp_pkg::M_TDATA_W'({in_data.color, pz, py, px});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/depth_pixel_to_point_top.sv
// An accepted pixel passes four register stages (offset, two multiplier ranks,
// rounding and saturation) to its point on m_tvalid. Throughput: one item per cycle
// while m_tready stays high; under backpressure each stage holds its item.
// A pixel with zero depth is accepted and produces no result.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and loads the
// configuration registers with their default values.
`default_nettype none

`include "depth_pixel_to_point_top_defines.svh"

module depth_pixel_to_point_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dpp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [dpp_pkg::DATA_W-1:0]    pwdata,
    output logic      [dpp_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // depth, column, row, red, green, blue
    input  wire logic [dpp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // point_x, point_y, point_z, packed_color
    output logic      [dpp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int COL_LO = dpp_pkg::DEPTH_BITS;
    localparam int ROW_LO = COL_LO + dpp_pkg::COORD_BITS;
    localparam int RED_LO = ROW_LO + dpp_pkg::COORD_BITS;
    localparam int GRN_LO = RED_LO + dpp_pkg::COLOR_BITS;
    localparam int BLU_LO = GRN_LO + dpp_pkg::COLOR_BITS;

    dpp_pkg::cfg_t   cfg;
    logic            front_valid;
    dpp_pkg::front_t front_data;
    logic            scale_ready;
    logic            prod_valid;
    dpp_pkg::prod_t  prod_data;
    logic            sat_ready;
    logic [dpp_pkg::DEPTH_BITS-1:0] in_depth;

    assign in_depth = s_tdata[dpp_pkg::DEPTH_BITS-1:0];

    dpp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .depth     (in_depth),
        .column    (s_tdata[COL_LO +: dpp_pkg::COORD_BITS]),
        .row       (s_tdata[ROW_LO +: dpp_pkg::COORD_BITS]),
        .red       (s_tdata[RED_LO +: dpp_pkg::COLOR_BITS]),
        .green     (s_tdata[GRN_LO +: dpp_pkg::COLOR_BITS]),
        .blue      (s_tdata[BLU_LO +: dpp_pkg::COLOR_BITS]),
        .out_valid (front_valid),
        .out_ready (scale_ready),
        .out_data  (front_data)
    );

    dpp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (front_valid),
        .in_ready  (scale_ready),
        .in_data   (front_data),
        .out_valid (prod_valid),
        .out_ready (sat_ready),
        .out_data  (prod_data)
    );

    dpp_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (sat_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `DPP_ASSERT_NXT(a_zero_depth_dropped, s_tvalid && s_tready && (in_depth == '0), !front_valid, "zero-depth pixel entered the pipeline")
    `DPP_ASSERT_NXT(a_front_holds, front_valid && !scale_ready, front_valid, "first stage lost an item under stall")
    `DPP_ASSERT_NXT(a_prod_holds, prod_valid && !sat_ready, prod_valid, "multiplier stage lost an item under stall")
    `DPP_ASSERT_IMP(a_depth_positive, m_tvalid, !m_tdata[2 * dpp_pkg::POINT_W - 1], "point_y came out negative")

endmodule

`default_nettype wire
